// ===== design/hsn_pkg.sv =====
// Shared types and constants for the horizontal surface normal stencil.
`timescale 1ns / 1ps

package hsn_pkg;

	localparam int REG_IDX_BITS = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_Z  = 2'd2;

	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [10:0] HEIGHT_RESET = 11'd480;
	localparam logic [10:0] MAX_HEIGHT   = 11'd1024;
	localparam logic [10:0] MIN_SIZE     = 11'd3;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 15;
	localparam int Q14_ONE    = 16384;
	localparam int OUT_DW     = 72;

	typedef struct packed {
		logic       take;
		logic       rd;
		logic       load;
		logic       mul;
		logic       xprod;
		logic       shr;
		logic       sq;
		logic       sum;
		logic       sqrt;
		logic       div_init;
		logic       div_step;
		logic       div_last;
		logic [1:0] k;
		logic       fin;
		logic       out_load;
	} hsn_cmd_t;

	typedef struct packed {
		logic emit;
		logic missing;
		logic big;
		logic out_free;
	} hsn_sts_t;

endpackage

// ===== design/horizontal_surface_normal_stencil.sv =====
// Top level of the horizontal surface normal stencil with its register port.
`timescale 1ns / 1ps

// Points enter one at a time in raster order. A point that completes no interior
// pixel returns to idle after the row stores are written; one whose neighborhood
// lacks a point goes straight to the result; a full normal runs the cross product,
// the one-bit right shifts that bring it below 2^31 (at most 2*COORD_BITS - 30, never
// below zero), the 32-step square root and the three 15-step divisions. A finished
// result waits in the output register while the next point is taken. Writing the
// width or height restarts the frame at row 0, column 0.
module horizontal_surface_normal_stencil import hsn_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// x_coord, y_coord, z_coord from the lowest bit up.
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pixel_row, pixel_col, normal_x, normal_y, normal_z from the lowest bit up.
	output logic [OUT_DW-1:0]                     m_axis_tdata,
	// accepted.
	output logic                                  m_axis_tuser,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [3:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	logic [10:0]        width_q, height_q;
	logic signed [15:0] min_z_q;
	logic               wr, restart;
	logic [REG_IDX_BITS-1:0] idx;
	hsn_cmd_t           cmd;
	hsn_sts_t           sts;
	logic [9:0]         o_row, o_col;
	logic signed [15:0] o_nx, o_ny, o_nz;

	assign pready  = 1'b1;
	assign idx     = paddr[3:2];
	assign wr      = psel && penable && pwrite;
	assign restart = wr && ((idx == REG_WIDTH) || (idx == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			min_z_q  <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[10:0];
				REG_MIN_Z:  min_z_q  <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_MIN_Z:  prdata = 32'(min_z_q);
			default:    prdata = '0;
		endcase
	end

	hsn_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hsn_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.in_point               (s_axis_tdata[3*COORD_BITS-1:0]),
		.image_width            (width_q),
		.image_height           (height_q),
		.min_vertical_component (min_z_q),
		.restart                (restart),
		.out_tready             (m_axis_tready),
		.out_tvalid             (m_axis_tvalid),
		.out_row                (o_row),
		.out_col                (o_col),
		.out_nx                 (o_nx),
		.out_ny                 (o_ny),
		.out_nz                 (o_nz),
		.out_accepted           (m_axis_tuser)
	);

	assign m_axis_tdata = {4'b0000, o_nz, o_ny, o_nx, o_col, o_row};

endmodule

// ===== design/hsn_controller.sv =====
// Sequencing state machine for the surface normal stencil.
`timescale 1ns / 1ps

module hsn_controller import hsn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hsn_sts_t sts,
	output hsn_cmd_t cmd
);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_READ  = 13'b0000000000010,
		ST_LOAD  = 13'b0000000000100,
		ST_MUL   = 13'b0000000001000,
		ST_CROSS = 13'b0000000010000,
		ST_SHR   = 13'b0000000100000,
		ST_SQ    = 13'b0000001000000,
		ST_SUM   = 13'b0000010000000,
		ST_SQRT  = 13'b0000100000000,
		ST_DIVI  = 13'b0001000000000,
		ST_DIVS  = 13'b0010000000000,
		ST_FIN   = 13'b0100000000000,
		ST_OUT   = 13'b1000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] k_q, k_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		k_d      = k_q;
		cmd      = '0;
		cmd.k    = k_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid) state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				if (!sts.emit) state_d = ST_IDLE;
				else if (sts.missing) state_d = ST_FIN;
				else state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CROSS;
			end
			ST_CROSS: begin
				cmd.xprod = 1'b1;
				state_d   = ST_SHR;
			end
			ST_SHR: begin
				cmd.shr = 1'b1;
				if (!sts.big) state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt = 1'b1;
				cnt_d    = cnt_q + 5'd1;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					cnt_d   = '0;
					k_d     = '0;
					state_d = ST_DIVI;
				end
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cmd.div_last = 1'b1;
					cnt_d        = '0;
					if (k_q == 2'd2) begin
						state_d = ST_FIN;
					end else begin
						k_d     = k_q + 2'd1;
						state_d = ST_DIVI;
					end
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.out_load = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
		end
	end

	a_one_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (k_q != 2'd3))
		else $error("component index out of range");

endmodule

// ===== design/hsn_datapath.sv =====
// Row stores, window, cross product, square root and divider of the stencil.
`timescale 1ns / 1ps

module hsn_datapath import hsn_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hsn_cmd_t                cmd,
	output hsn_sts_t                sts,
	input  logic [3*COORD_BITS-1:0] in_point,
	input  logic [10:0]             image_width,
	input  logic [10:0]             image_height,
	input  logic signed [15:0]      min_vertical_component,
	input  logic                    restart,
	input  logic                    out_tready,
	output logic                    out_tvalid,
	output logic [9:0]              out_row,
	output logic [9:0]              out_col,
	output logic signed [15:0]      out_nx,
	output logic signed [15:0]      out_ny,
	output logic signed [15:0]      out_nz,
	output logic                    out_accepted
);

	localparam int CB = COORD_BITS;
	localparam int PW = 3 * CB;
	localparam int DB = CB + 1;
	localparam int PB = 2 * DB;
	localparam int NB = PB + 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

	logic [PW-1:0] older_mem [MAX_WIDTH];
	logic [PW-1:0] newer_mem [MAX_WIDTH];

	logic [PW-1:0] cur_q, top_q, mid_q;
	logic [PW-1:0] win0_q, win1_q, win2_q, win4_q, win5_q;
	logic [CW-1:0] col_q;
	logic [9:0]    row_q;
	logic [9:0]    er_q, ec_q;
	logic          missing_q;

	logic signed [DB-1:0] a_q [3];
	logic signed [DB-1:0] b_q [3];
	logic signed [PB-1:0] p_q [6];
	logic        [NB-1:0] mg_q [3];
	logic                 ns_q [3];
	logic        [30:0]   m31 [3];
	logic        [61:0]   sq_q [3];
	logic        [63:0]   rad_q, res_q, bit_q, trial;
	logic        [31:0]   mag;
	logic        [47:0]   rem_q, den_q;
	logic        [13:0]   quo_q;
	logic        [14:0]   q_q [3];
	logic        [14:0]   quo_new;
	logic                 ge;
	logic                 big;

	logic signed [15:0] fx_q, fy_q, fz_q;
	logic               facc_q;
	logic signed [15:0] vx, vy, vz;

	logic [EW-1:0] wext, eff_w;
	logic [10:0]   eff_h;
	logic          col_wrap, row_wrap;

	always_comb begin
		wext = EW'(image_width);
		if (wext < EW'(MIN_SIZE)) eff_w = EW'(MIN_SIZE);
		else if (wext > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
		else eff_w = wext;
		if (image_height < MIN_SIZE) eff_h = MIN_SIZE;
		else if (image_height > MAX_HEIGHT) eff_h = MAX_HEIGHT;
		else eff_h = image_height;
		col_wrap = (EW'(col_q) + EW'(1)) >= eff_w;
		row_wrap = (11'(row_q) + 11'd1) >= eff_h;
	end

	always_comb begin
		sts.emit     = (row_q >= 10'd2) && (col_q >= CW'(2));
		sts.missing  = (cur_q == '0) || (win2_q == '0) || (win5_q == '0) ||
		               (win1_q == '0) || (top_q == '0);
		sts.big      = big;
		sts.out_free = !out_tvalid || out_tready;
	end

	always_comb begin
		big = 1'b0;
		for (int k = 0; k < 3; k++) begin
			m31[k] = 31'(mg_q[k]);
			if (64'(mg_q[k]) >= 64'h8000_0000) big = 1'b1;
		end
		trial   = res_q + bit_q;
		mag     = res_q[31:0];
		ge      = rem_q >= den_q;
		quo_new = {quo_q, ge};
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			top_q <= older_mem[col_q];
			mid_q <= newer_mem[col_q];
		end
		if (cmd.load) begin
			older_mem[col_q] <= mid_q;
			newer_mem[col_q] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
			win4_q <= '0;
			win5_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			win1_q <= win0_q;
			win0_q <= top_q;
			win2_q <= mid_q;
			win5_q <= win4_q;
			win4_q <= cur_q;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? 10'd0 : row_q + 10'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) cur_q <= in_point;
		if (cmd.load) begin
			er_q      <= row_q - 10'd1;
			ec_q      <= 10'(col_q - CW'(1));
			missing_q <= sts.missing;
			for (int k = 0; k < 3; k++) begin
				a_q[k] <= DB'($signed(cur_q[k*CB +: CB])) - DB'($signed(win1_q[k*CB +: CB]));
				b_q[k] <= DB'($signed(win5_q[k*CB +: CB])) - DB'($signed(top_q[k*CB +: CB]));
			end
		end
		if (cmd.mul) begin
			p_q[0] <= a_q[1] * b_q[2];
			p_q[1] <= a_q[2] * b_q[1];
			p_q[2] <= a_q[2] * b_q[0];
			p_q[3] <= a_q[0] * b_q[2];
			p_q[4] <= a_q[0] * b_q[1];
			p_q[5] <= a_q[1] * b_q[0];
		end
		if (cmd.xprod) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [NB-1:0] n;
				n = NB'(p_q[2*k]) - NB'(p_q[2*k+1]);
				ns_q[k] <= n < 0;
				mg_q[k] <= (n < 0) ? NB'(-n) : NB'(n);
			end
		end
		if (cmd.shr && big) begin
			for (int k = 0; k < 3; k++) mg_q[k] <= mg_q[k] >> 1;
		end
		if (cmd.sq) begin
			for (int k = 0; k < 3; k++) sq_q[k] <= m31[k] * m31[k];
		end
		if (cmd.sum) begin
			rad_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
			res_q <= '0;
			bit_q <= 64'(1) << 62;
		end
		if (cmd.sqrt) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			rem_q <= (48'(m31[cmd.k]) << 15) + 48'(mag);
			den_q <= 48'(mag) << 15;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (ge) rem_q <= rem_q - den_q;
			den_q <= den_q >> 1;
			quo_q <= quo_new[13:0];
			if (cmd.div_last) q_q[cmd.k] <= (mag == 32'd0) ? 15'(m31[cmd.k]) : quo_new;
		end
		if (cmd.fin) begin
			if (missing_q || (vz < min_vertical_component)) begin
				fx_q   <= '0;
				fy_q   <= '0;
				fz_q   <= '0;
				facc_q <= 1'b0;
			end else begin
				fx_q   <= vx;
				fy_q   <= vy;
				fz_q   <= vz;
				facc_q <= 1'b1;
			end
		end
	end

	always_comb begin
		vx = (ns_q[0] ^ ns_q[2]) ? -16'(q_q[0]) : 16'(q_q[0]);
		vy = (ns_q[1] ^ ns_q[2]) ? -16'(q_q[1]) : 16'(q_q[1]);
		vz = 16'(q_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			out_tvalid <= 1'b1;
		end else if (out_tready) begin
			out_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_row      <= er_q;
			out_col      <= ec_q;
			out_nx       <= fx_q;
			out_ny       <= fy_q;
			out_nz       <= fz_q;
			out_accepted <= facc_q;
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_q) < eff_w)
		else $error("column counter beyond the row width");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_tvalid || out_tready))
		else $error("result register overwritten before its transfer");

	a_unit_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_last && mag != 32'd0) |-> (quo_new <= 15'(Q14_ONE)))
		else $error("normalized component above one");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the horizontal surface normal stencil.
`timescale 1ns / 1ps

module testbench import hsn_pkg::*; ();

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} point_t;

	typedef struct packed {
		logic [3:0]         pad;
		logic signed [15:0] nz;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
		logic [9:0]         col;
		logic [9:0]         row;
	} normal_word_t;

	typedef struct {
		normal_word_t word;
		bit           acc;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// x_coord, y_coord, z_coord from the lowest bit up.
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// pixel_row, pixel_col, normal_x, normal_y, normal_z from the lowest bit up.
	logic [OUT_DW-1:0] m_axis_tdata;
	// accepted.
	logic m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	horizontal_surface_normal_stencil DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	point_t       points_pending[$];
	normal_t      normals_due[$];
	bit           no_gaps = 1'b0;
	int unsigned  point_gap = 0;
	int unsigned  result_stall = 0;
	int unsigned  mismatches = 0;
	int unsigned  points_sent = 0;
	int unsigned  normals_seen = 0;
	int unsigned  normals_accepted = 0;
	int unsigned  phases_run = 0;
	int unsigned  quiet_cycles = 0;
	bit           apb_hit = 1'b0;

	// Predictor state.
	point_t       older_row[1024];
	point_t       newer_row[1024];
	point_t       win[6];
	int unsigned  col_cnt = 0;
	int unsigned  row_cnt = 0;
	logic [10:0]  cfg_width = WIDTH_RESET;
	logic [10:0]  cfg_height = HEIGHT_RESET;
	logic signed [15:0] cfg_min_z = '0;

	task automatic enqueue_point(point_t p);
		points_pending.insert(points_pending.size(), p);
	endtask

	function automatic bit is_hole(point_t p);
		return p.x == 0 && p.y == 0 && p.z == 0;
	endfunction

	function automatic int unsigned clamp_size(logic [10:0] v, int unsigned hi);
		if (v < MIN_SIZE)
			return 32'(MIN_SIZE);
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	function automatic normal_t surface_normal(point_t c, point_t ne, point_t nw,
			point_t sw, point_t se);
		normal_t res;
		longint a[3], b[3], n[3], nv[3];
		longint unsigned m[3], sum, mag, probe, q;
		res.word = '0;
		res.acc = 1'b0;
		if (is_hole(c) || is_hole(ne) || is_hole(nw) || is_hole(sw) || is_hole(se))
			return res;
		a[0] = longint'(ne.x) - longint'(sw.x);
		a[1] = longint'(ne.y) - longint'(sw.y);
		a[2] = longint'(ne.z) - longint'(sw.z);
		b[0] = longint'(nw.x) - longint'(se.x);
		b[1] = longint'(nw.y) - longint'(se.y);
		b[2] = longint'(nw.z) - longint'(se.z);
		n[0] = a[1] * b[2] - a[2] * b[1];
		n[1] = a[2] * b[0] - a[0] * b[2];
		n[2] = a[0] * b[1] - a[1] * b[0];
		for (int k = 0; k < 3; k++)
			m[k] = n[k] < 0 ? longint'(-n[k]) : longint'(n[k]);
		while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
			for (int k = 0; k < 3; k++)
				m[k] = m[k] >> 1;
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		mag = 0;
		probe = 64'd1 << 62;
		while (probe > sum)
			probe = probe >> 2;
		while (probe != 0) begin
			if (sum >= mag + probe) begin
				sum = sum - (mag + probe);
				mag = (mag >> 1) + probe;
			end else begin
				mag = mag >> 1;
			end
			probe = probe >> 2;
		end
		for (int k = 0; k < 3; k++) begin
			q = m[k];
			if (mag != 0)
				q = (2 * q * Q14_ONE + mag) / (2 * mag);
			nv[k] = n[k] < 0 ? -longint'(q) : longint'(q);
		end
		if (n[2] < 0)
			for (int k = 0; k < 3; k++)
				nv[k] = -nv[k];
		if (nv[2] < longint'(cfg_min_z))
			return res;
		res.word.nx = 16'(nv[0]);
		res.word.ny = 16'(nv[1]);
		res.word.nz = 16'(nv[2]);
		res.acc = 1'b1;
		return res;
	endfunction

	task automatic predict_point(point_t cur);
		int unsigned w, h, c, r;
		point_t top, mid;
		normal_t res;
		w = clamp_size(cfg_width, 1024);
		h = clamp_size(cfg_height, 32'(MAX_HEIGHT));
		c = col_cnt >= w ? 0 : col_cnt;
		r = row_cnt >= h ? 0 : row_cnt;
		top = older_row[c];
		mid = newer_row[c];
		if (r >= 2 && c >= 2) begin
			res = surface_normal(win[2], cur, win[5], win[1], top);
			res.word.row = 10'(r - 1);
			res.word.col = 10'(c - 1);
			normals_due.insert(normals_due.size(), res);
		end
		win[1] = win[0];
		win[0] = top;
		win[3] = win[2];
		win[2] = mid;
		win[5] = win[4];
		win[4] = cur;
		older_row[c] = mid;
		newer_row[c] = cur;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_cnt = c;
		row_cnt = r;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (points_pending.size() > 0 && !no_gaps && $urandom_range(0, 7) != 0) begin
					point_gap = $urandom_range(1, 7);
					s_axis_tvalid <= 1'b0;
				end else if (points_pending.size() > 0) begin
					s_axis_tdata <= points_pending.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end else if (!s_axis_tvalid) begin
				if (point_gap > 0) begin
					point_gap--;
				end else if (points_pending.size() > 0) begin
					s_axis_tdata <= points_pending.pop_front();
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		normal_t due;
		normal_word_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				normals_seen++;
				if (normals_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected normal transfer: row %0d col %0d",
							got.row, got.col);
				end else begin
					due = normals_due.pop_front();
					if (due.acc)
						normals_accepted++;
					if (got.row !== due.word.row || got.col !== due.word.col ||
							got.nx !== due.word.nx || got.ny !== due.word.ny ||
							got.nz !== due.word.nz || m_axis_tuser !== due.acc) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected r%0d c%0d n(%0d,%0d,%0d) acc %0d",
								due.word.row, due.word.col, due.word.nx, due.word.ny,
								due.word.nz, due.acc);
							$display("          got r%0d c%0d n(%0d,%0d,%0d) acc %0d",
								got.row, got.col, got.nx, got.ny, got.nz, m_axis_tuser);
						end
					end
				end
				result_stall = no_gaps ? 0 : $urandom_range(0, 7);
			end else if (result_stall > 0) begin
				result_stall--;
			end
			m_axis_tready <= result_stall == 0;
			if (s_axis_tvalid && s_axis_tready) begin
				points_sent++;
				predict_point(s_axis_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || apb_hit)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 3000) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic settle();
		while (points_pending.size() > 0 || s_axis_tvalid || normals_due.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		apb_hit = 1'b1;
		case (idx)
			REG_WIDTH: begin
				cfg_width = value[10:0];
				col_cnt = 0;
				row_cnt = 0;
			end
			REG_HEIGHT: begin
				cfg_height = value[10:0];
				col_cnt = 0;
				row_cnt = 0;
			end
			REG_MIN_Z: cfg_min_z = value[15:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		apb_hit = 1'b0;
	endtask

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0001;
			3: return 16'hFFFF;
			4: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic point_t make_point(int style, int r, int c, int sx, int sy,
			int gx, int gy);
		point_t p;
		case (style)
			0: begin
				p.x = 16'($urandom());
				p.y = 16'($urandom());
				p.z = 16'($urandom());
			end
			1: begin
				p.x = pick_extreme();
				p.y = pick_extreme();
				p.z = pick_extreme();
			end
			default: begin
				p.x = 16'(c * sx + $urandom_range(0, 6) - 3);
				p.y = 16'(r * sy + $urandom_range(0, 6) - 3);
				p.z = 16'(1500 + c * gx + r * gy + $urandom_range(0, 10) - 5);
			end
		endcase
		if ($urandom_range(0, 15) == 0)
			p = '0;
		return p;
	endfunction

	task automatic send_points(int unsigned count, int unsigned w, int style);
		int sx, sy, gx, gy;
		sx = $urandom_range(0, 400) - 200;
		sy = $urandom_range(0, 400) - 200;
		gx = $urandom_range(0, 200) - 100;
		gy = $urandom_range(0, 200) - 100;
		for (int unsigned i = 0; i < count; i++)
			enqueue_point(make_point(style, i / w, i % w, sx, sy, gx, gy));
		phases_run++;
	endtask

	initial begin
		point_t p;
		int unsigned w, h, count;
		logic [31:0] min_z;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_MIN_Z, -16384);
		// Extreme coordinates, a flat patch of identical points, and a hole at the centre.
		no_gaps = 1'b1;
		for (int i = 0; i < 9; i++) begin
			p.x = i[0] ? 16'h7FFF : 16'h8000;
			p.y = i[1] ? 16'h8000 : 16'h7FFF;
			p.z = (i % 3 == 0) ? 16'h7FFF : 16'h8000;
			enqueue_point(p);
		end
		p.x = 16'd250;
		p.y = -16'sd40;
		p.z = 16'd900;
		repeat (9) enqueue_point(p);
		for (int i = 0; i < 9; i++) begin
			p.x = 16'($urandom());
			p.y = 16'($urandom());
			p.z = 16'($urandom());
			enqueue_point(i == 4 ? point_t'('0) : p);
		end
		settle();
		write_reg(REG_MIN_Z, 16384);
		enqueue_point('{z: 16'd100, y: 16'd0, x: 16'd0});
		repeat (2) enqueue_point('{z: 16'd100, y: 16'd0, x: 16'd10});
		repeat (3) enqueue_point('{z: 16'd100, y: 16'd10, x: 16'd0});
		repeat (3) enqueue_point('{z: 16'd100, y: 16'd10, x: 16'd10});
		settle();
		// Oversized width and height are clamped; no interior pixel is reached here.
		write_reg(REG_WIDTH, 2047);
		write_reg(REG_HEIGHT, 2047);
		send_points(40, 1024, 0);
		settle();
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 1024);
		send_points(30, 3, 2);
		settle();
		while (points_sent < 1400) begin
			no_gaps = $urandom_range(0, 3) == 0;
			w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12);
			h = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 10);
			case ($urandom_range(0, 4))
				0: min_z = -16384;
				1: min_z = 16384;
				2: min_z = 0;
				default: min_z = $urandom_range(0, 32768) - 16384;
			endcase
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			write_reg(REG_MIN_Z, min_z);
			w = clamp_size(11'(w), 1024);
			h = clamp_size(11'(h), 32'(MAX_HEIGHT));
			count = w * h * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				count = count - $urandom_range(0, w * h - 1);
			send_points(count, w, $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2);
			settle();
		end
		$display("covered %0d points in %0d phases, %0d normals checked, %0d accepted",
			points_sent, phases_run, normals_seen, normals_accepted);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatching transfers", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
